// ----- hw/rtl/chip8_instruction_execute_macros.svh -----
// Assertion macros shared by the CHIP-8 execute unit RTL.
// Each macro expands to a clocked concurrent assertion on aclk, disabled in reset.
// Synthesis builds see empty bodies.
`ifndef CHIP8_INSTRUCTION_EXECUTE_MACROS_SVH
`define CHIP8_INSTRUCTION_EXECUTE_MACROS_SVH

`ifndef SYNTHESIS

`define C8IE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

`define C8IE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define C8IE_ASSERT(label, prop, msg)

`define C8IE_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ----- hw/rtl/c8ie_pkg.sv -----
// Shared types and constants for the CHIP-8 execute unit.
// No dependencies; used by every module of the block.
package c8ie_pkg;

    localparam int PC_W    = 12;
    localparam int INSTR_W = 16;
    localparam int DATA_W  = 8;
    localparam int NUM_REGS = 16;
    localparam int REG_AW  = 4;

    localparam logic [PC_W-1:0]    PC_RESET   = 12'h200;
    localparam logic [INSTR_W-1:0] INSTR_CLS  = 16'h00E0;
    localparam logic [INSTR_W-1:0] INSTR_RET  = 16'h00EE;

    // Major opcode, instruction bits 15:12.
    localparam logic [3:0] OP_SYS     = 4'h0;
    localparam logic [3:0] OP_JP      = 4'h1;
    localparam logic [3:0] OP_CALL    = 4'h2;
    localparam logic [3:0] OP_SE_IMM  = 4'h3;
    localparam logic [3:0] OP_SNE_IMM = 4'h4;
    localparam logic [3:0] OP_SE_REG  = 4'h5;
    localparam logic [3:0] OP_LD_IMM  = 4'h6;
    localparam logic [3:0] OP_ADD_IMM = 4'h7;
    localparam logic [3:0] OP_ALU     = 4'h8;
    localparam logic [3:0] OP_SNE_REG = 4'h9;
    localparam logic [3:0] OP_LD_I    = 4'hA;
    localparam logic [3:0] OP_JP_V0   = 4'hB;

    // Register-register sub-opcode, instruction bits 3:0 of group 8.
    localparam logic [3:0] ALU_LD  = 4'h0;
    localparam logic [3:0] ALU_OR  = 4'h1;
    localparam logic [3:0] ALU_AND = 4'h2;
    localparam logic [3:0] ALU_XOR = 4'h3;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_OVER   = 2'd1,
        ST_UNDER  = 2'd2,
        ST_UNIMPL = 2'd3
    } status_t;

    typedef struct packed {
        logic [DATA_W-1:0] rx;
        logic [DATA_W-1:0] ry;
        logic [DATA_W-1:0] v0;
    } opnd_t;

    typedef struct packed {
        logic              en;
        logic [REG_AW-1:0] addr;
        logic [DATA_W-1:0] data;
    } rf_wr_t;

    typedef struct packed {
        logic            push;
        logic            pop;
        logic [PC_W-1:0] data;
    } stk_ctrl_t;

    typedef struct packed {
        logic            empty;
        logic            full;
        logic [PC_W-1:0] top;
    } stk_stat_t;

endpackage

// ----- hw/rtl/c8ie_exec.sv -----
// Combinational decode and execute of one CHIP-8 instruction.
// Depends on c8ie_pkg for opcode constants and interface structs.
module c8ie_exec
    import c8ie_pkg::*;
(
    input  logic [INSTR_W-1:0] instr,
    input  logic [PC_W-1:0]    pc,
    input  logic [PC_W-1:0]    index,
    input  opnd_t              ops,
    input  stk_stat_t          stk_stat,
    output logic [PC_W-1:0]    pc_next,
    output logic [PC_W-1:0]    index_next,
    output logic [DATA_W-1:0]  x_val,
    output status_t            status,
    output rf_wr_t             rf_wr,
    output stk_ctrl_t          stk_ctrl
);

    logic [PC_W-1:0]   nnn;
    logic [DATA_W-1:0] kk;
    logic [PC_W-1:0]   pc_inc;
    logic [PC_W-1:0]   pc_skip;

    assign nnn     = instr[PC_W-1:0];
    assign kk      = instr[DATA_W-1:0];
    assign pc_inc  = pc + PC_W'(2);
    assign pc_skip = pc + PC_W'(4);

    always_comb begin
        pc_next       = pc_inc;
        index_next    = index;
        status        = ST_OK;
        rf_wr.en      = 1'b0;
        rf_wr.addr    = instr[11:8];
        rf_wr.data    = kk;
        stk_ctrl.push = 1'b0;
        stk_ctrl.pop  = 1'b0;
        stk_ctrl.data = pc_inc;

        case (instr[15:12])
            OP_SYS: begin
                if (instr == INSTR_CLS) begin
                    status = ST_UNIMPL;
                end else if (instr == INSTR_RET) begin
                    if (stk_stat.empty) begin
                        status = ST_UNDER;
                    end else begin
                        stk_ctrl.pop = 1'b1;
                        pc_next      = stk_stat.top;
                    end
                end
                // Any other system call word only advances the PC.
            end
            OP_JP: begin
                pc_next = nnn;
            end
            OP_CALL: begin
                if (stk_stat.full) begin
                    status = ST_OVER;
                end else begin
                    stk_ctrl.push = 1'b1;
                    pc_next       = nnn;
                end
            end
            OP_SE_IMM: begin
                if (ops.rx == kk) pc_next = pc_skip;
            end
            OP_SNE_IMM: begin
                if (ops.rx != kk) pc_next = pc_skip;
            end
            OP_SE_REG: begin
                if (ops.rx == ops.ry) pc_next = pc_skip;
            end
            OP_LD_IMM: begin
                rf_wr.en = 1'b1;
            end
            OP_ADD_IMM: begin
                rf_wr.en   = 1'b1;
                rf_wr.data = ops.rx + kk;
            end
            OP_ALU: begin
                rf_wr.en = 1'b1;
                case (instr[3:0])
                    ALU_LD:  rf_wr.data = ops.ry;
                    ALU_OR:  rf_wr.data = ops.rx | ops.ry;
                    ALU_AND: rf_wr.data = ops.rx & ops.ry;
                    ALU_XOR: rf_wr.data = ops.rx ^ ops.ry;
                    default: begin
                        rf_wr.en = 1'b0;
                        status   = ST_UNIMPL;
                    end
                endcase
            end
            OP_SNE_REG: begin
                if (ops.rx != ops.ry) pc_next = pc_skip;
            end
            OP_LD_I: begin
                index_next = nnn;
            end
            OP_JP_V0: begin
                pc_next = nnn + PC_W'(ops.v0);
            end
            default: begin
                status = ST_UNIMPL;
            end
        endcase
    end

    // The write always targets register x, so its value after the step is either the
    // written data or the unchanged operand.
    assign x_val = rf_wr.en ? rf_wr.data : ops.rx;

endmodule

// ----- hw/rtl/c8ie_regfile.sv -----
// Sixteen 8-bit general registers with operand prefetch and write forwarding.
// Depends on c8ie_pkg for the operand and write-port structs.
module c8ie_regfile
    import c8ie_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              rd_en,
    input  logic [REG_AW-1:0] rd_x,
    input  logic [REG_AW-1:0] rd_y,
    input  rf_wr_t            wr,
    output opnd_t             ops
);

    logic [DATA_W-1:0]   mem [NUM_REGS];
    logic [NUM_REGS-1:0] vld_reg;
    logic [DATA_W-1:0]   rx_reg;
    logic [DATA_W-1:0]   ry_reg;
    logic [DATA_W-1:0]   v0_reg;

    // Valid bits stand in for clearing the array at reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            v0_reg  <= '0;
        end else if (wr.en) begin
            vld_reg[wr.addr] <= 1'b1;
            if (wr.addr == '0) v0_reg <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.en) mem[wr.addr] <= wr.data;
    end

    // Operands are read when the beat is taken in. The instruction executing in the
    // same cycle may write the same register, so its result is forwarded.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (wr.en && wr.addr == rd_x) begin
                rx_reg <= wr.data;
            end else if (!vld_reg[rd_x]) begin
                rx_reg <= '0;
            end else begin
                rx_reg <= mem[rd_x];
            end
            if (wr.en && wr.addr == rd_y) begin
                ry_reg <= wr.data;
            end else if (!vld_reg[rd_y]) begin
                ry_reg <= '0;
            end else begin
                ry_reg <= mem[rd_y];
            end
        end
    end

    assign ops.rx = rx_reg;
    assign ops.ry = ry_reg;
    assign ops.v0 = v0_reg;

endmodule

// ----- hw/rtl/c8ie_stack.sv -----
// Return stack with a registered top-of-stack read.
// Depends on c8ie_pkg and on the assertion macros header.
`include "chip8_instruction_execute_macros.svh"

module c8ie_stack
    import c8ie_pkg::*;
#(
    parameter int STACK_DEPTH = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  stk_ctrl_t ctrl,
    output stk_stat_t stat
);

    localparam int SP_W = $clog2(STACK_DEPTH + 1);
    localparam int AW   = $clog2(STACK_DEPTH);

    logic [PC_W-1:0] mem [STACK_DEPTH];
    logic [SP_W-1:0] sp_reg;
    logic [SP_W-1:0] sp_next;
    logic [SP_W-1:0] sp_dec;
    logic [AW-1:0]   rd_addr;
    logic [PC_W-1:0] top_reg;

    always_comb begin
        sp_next = sp_reg;
        if (ctrl.push) begin
            sp_next = sp_reg + 1'b1;
        end else if (ctrl.pop) begin
            sp_next = sp_reg - 1'b1;
        end
    end

    // The entry below the next stack pointer becomes the new top.
    assign sp_dec  = sp_next - 1'b1;
    assign rd_addr = (sp_next == '0) ? '0 : sp_dec[AW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_reg <= '0;
        end else begin
            sp_reg <= sp_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.push) begin
            mem[sp_reg[AW-1:0]] <= ctrl.data;
            top_reg             <= ctrl.data;
        end else begin
            top_reg <= mem[rd_addr];
        end
    end

    assign stat.empty = (sp_reg == '0);
    assign stat.full  = (sp_reg == SP_W'(STACK_DEPTH));
    assign stat.top   = top_reg;

    `C8IE_ASSERT(a_sp_in_range, sp_reg <= SP_W'(STACK_DEPTH), "stack pointer beyond depth")
    `C8IE_ASSERT_NEXT(a_push_grows, ctrl.push, sp_reg == SP_W'($past(sp_reg) + 1'b1), "push lost")

endmodule

// ----- hw/rtl/chip8_instruction_execute.sv -----
// Top level of the CHIP-8 execute unit: input register, execute, result register.
// Depends on c8ie_pkg, c8ie_exec, c8ie_regfile, c8ie_stack and the macros header.
//
//  Port group   Dir  Payload (low bit up)
//  s_axis       in   s_tdata[15:0] instruction
//  m_axis       out  m_tdata next_pc[11:0], index_value[23:12], x_reg_value[31:24];
//                    m_tuser status[1:0]
//
// An instruction beat is registered in instr_reg, executed once the result register is
// free and its result registered, so one instruction completes per cycle while the
// output is not stalled.
// Operand reads happen as a beat is taken in, with forwarding from the instruction
// executing alongside. A stalled result holds while one more instruction waits in the
// input register. Reset sets PC to 0x200 and clears index, registers and stack pointer.
`include "chip8_instruction_execute_macros.svh"

module chip8_instruction_execute
    import c8ie_pkg::*;
#(
    parameter int STACK_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // instruction[15:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // next_pc[11:0], index_value[23:12], x_reg_value[31:24]
    output logic [1:0]  m_tuser    // status[1:0]
);

    logic               in_vld_reg;
    logic               in_vld_next;
    logic [INSTR_W-1:0] instr_reg;
    logic [PC_W-1:0]    pc_reg;
    logic [PC_W-1:0]    index_reg;
    logic               out_vld_reg;
    logic               out_vld_next;
    logic [31:0]        out_data_reg;
    logic [1:0]         out_user_reg;

    logic               s_fire;
    logic               exec_fire;

    opnd_t              ops;
    stk_stat_t          stk_stat;
    stk_ctrl_t          stk_ctrl;
    stk_ctrl_t          stk_ctrl_gated;
    rf_wr_t             rf_wr;
    rf_wr_t             rf_wr_gated;
    logic [PC_W-1:0]    pc_next;
    logic [PC_W-1:0]    index_next;
    logic [DATA_W-1:0]  x_val;
    status_t            status;

    assign exec_fire = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready  = !in_vld_reg || exec_fire;
    assign s_fire    = s_tvalid && s_tready;

    assign in_vld_next  = s_fire || (in_vld_reg && !exec_fire);
    assign out_vld_next = exec_fire || (out_vld_reg && !m_tready);

    c8ie_exec u_exec (
        .instr      (instr_reg),
        .pc         (pc_reg),
        .index      (index_reg),
        .ops        (ops),
        .stk_stat   (stk_stat),
        .pc_next    (pc_next),
        .index_next (index_next),
        .x_val      (x_val),
        .status     (status),
        .rf_wr      (rf_wr),
        .stk_ctrl   (stk_ctrl)
    );

    // State changes only when the instruction actually retires.
    always_comb begin
        rf_wr_gated         = rf_wr;
        rf_wr_gated.en      = rf_wr.en && exec_fire;
        stk_ctrl_gated      = stk_ctrl;
        stk_ctrl_gated.push = stk_ctrl.push && exec_fire;
        stk_ctrl_gated.pop  = stk_ctrl.pop && exec_fire;
    end

    c8ie_regfile u_regfile (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (s_fire),
        .rd_x    (s_tdata[11:8]),
        .rd_y    (s_tdata[7:4]),
        .wr      (rf_wr_gated),
        .ops     (ops)
    );

    c8ie_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (stk_ctrl_gated),
        .stat    (stk_stat)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            pc_reg      <= PC_RESET;
            index_reg   <= '0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (exec_fire) begin
                pc_reg    <= pc_next;
                index_reg <= index_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) instr_reg <= s_tdata;
        if (exec_fire) begin
            out_data_reg <= {x_val, index_next, pc_next};
            out_user_reg <= status;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    `C8IE_ASSERT_NEXT(a_exec_to_out, exec_fire, out_vld_reg, "executed beat not presented")
    `C8IE_ASSERT_NEXT(a_accept_held, s_fire, in_vld_reg, "accepted beat not registered")

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the CHIP-8 execute unit, driven over its stream ports.
// Depends on c8ie_pkg and chip8_instruction_execute; keeps its own model of the machine.
`timescale 1ns / 1ps

module tb_top;
    import c8ie_pkg::*;

    localparam int STACK_DEPTH = 16;
    localparam int RANDOM_ITEMS = 1800;
    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD_AT = 400;
    localparam int LONG_HOLD_CYCLES = 80;
    localparam int PAUSE_AT = 900;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [PC_W-1:0]   pc;
        logic [PC_W-1:0]   idx;
        logic [DATA_W-1:0] xv;
        status_t           st;
    } result_t;

    typedef struct packed {
        logic [INSTR_W-1:0] word;
        logic [4:0]         reps;
        logic               typed;
        result_t            res;
    } row_t;

    localparam int DIR_N = 31;
    localparam row_t DIRECTED [DIR_N] = '{
        '{16'h00E0, 5'd1,  1'b1, '{12'h202, 12'h000, 8'h00, ST_UNIMPL}},
        '{16'h00EE, 5'd1,  1'b1, '{12'h204, 12'h000, 8'h00, ST_UNDER}},
        '{16'h0123, 5'd1,  1'b1, '{12'h206, 12'h000, 8'h00, ST_OK}},
        '{16'h6AFF, 5'd1,  1'b1, '{12'h208, 12'h000, 8'hFF, ST_OK}},
        '{16'h7A01, 5'd1,  1'b1, '{12'h20A, 12'h000, 8'h00, ST_OK}},
        '{16'hAFFF, 5'd1,  1'b1, '{12'h20C, 12'hFFF, 8'h00, ST_OK}},
        '{16'h1FFE, 5'd1,  1'b1, '{12'hFFE, 12'hFFF, 8'h00, ST_OK}},
        '{16'h3F00, 5'd1,  1'b1, '{12'h002, 12'hFFF, 8'h00, ST_OK}},
        '{16'h4F00, 5'd1,  1'b1, '{12'h004, 12'hFFF, 8'h00, ST_OK}},
        '{16'h5AF7, 5'd1,  1'b1, '{12'h008, 12'hFFF, 8'h00, ST_OK}},
        '{16'h9AFC, 5'd1,  1'b1, '{12'h00A, 12'hFFF, 8'h00, ST_OK}},
        '{16'h6055, 5'd1,  1'b1, '{12'h00C, 12'hFFF, 8'h55, ST_OK}},
        '{16'hBFFF, 5'd1,  1'b1, '{12'h054, 12'hFFF, 8'h00, ST_OK}},
        '{16'h2ABC, 5'd16, 1'b0, '0},
        '{16'h2ABC, 5'd1,  1'b1, '{12'hABE, 12'hFFF, 8'h00, ST_OVER}},
        '{16'h00EE, 5'd16, 1'b0, '0},
        '{16'h00EE, 5'd1,  1'b1, '{12'h058, 12'hFFF, 8'h55, ST_UNDER}},
        '{16'h6133, 5'd1,  1'b0, '0},
        '{16'h8010, 5'd1,  1'b0, '0},
        '{16'h8121, 5'd1,  1'b0, '0},
        '{16'h8A12, 5'd1,  1'b0, '0},
        '{16'h8013, 5'd1,  1'b0, '0},
        '{16'h8AB4, 5'd1,  1'b1, '{12'h064, 12'hFFF, 8'h00, ST_UNIMPL}},
        '{16'hC0FF, 5'd1,  1'b0, '0},
        '{16'hDFFF, 5'd1,  1'b0, '0},
        '{16'hE19E, 5'd1,  1'b0, '0},
        '{16'hFFFF, 5'd1,  1'b1, '{12'h06C, 12'hFFF, 8'h00, ST_UNIMPL}},
        '{16'h0000, 5'd1,  1'b1, '{12'h06E, 12'hFFF, 8'h00, ST_OK}},
        '{16'h7FFF, 5'd1,  1'b0, '0},
        '{16'h5F07, 5'd1,  1'b0, '0},
        '{16'h9F00, 5'd1,  1'b0, '0}
    };

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;

    // Machine state as the testbench sees it.
    logic [PC_W-1:0]   pc_q;
    logic [PC_W-1:0]   idx_q;
    logic [DATA_W-1:0] vreg [NUM_REGS];
    logic [PC_W-1:0]   ret_stack [STACK_DEPTH];
    int                sp_q;

    result_t pending_results [$];
    int      status_count [4];
    int      sent_count;
    int      checked_count = 0;
    int      error_count = 0;
    int      cycle_count = 0;
    int      call_run;
    int      ret_run;
    bit      tx_quiet;
    bit      rx_quiet = 1'b0;

    chip8_instruction_execute #(
        .STACK_DEPTH(STACK_DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic void reset_machine();
        pc_q = PC_RESET;
        idx_q = '0;
        sp_q = 0;
        for (int i = 0; i < NUM_REGS; i++) vreg[i] = '0;
        for (int i = 0; i < STACK_DEPTH; i++) ret_stack[i] = '0;
    endfunction

    // Executes one instruction on the local copy of the machine.
    function automatic result_t execute_instr(input logic [INSTR_W-1:0] word);
        logic [3:0]        x;
        logic [3:0]        y;
        logic [PC_W-1:0]   nnn;
        logic [DATA_W-1:0] kk;
        result_t           r;
        x = word[11:8];
        y = word[7:4];
        nnn = word[11:0];
        kk = word[7:0];
        r.st = ST_OK;
        pc_q = pc_q + 12'd2;
        case (word[15:12])
            OP_SYS: begin
                if (word == INSTR_CLS) begin
                    r.st = ST_UNIMPL;
                end else if (word == INSTR_RET) begin
                    if (sp_q == 0) begin
                        r.st = ST_UNDER;
                    end else begin
                        sp_q--;
                        pc_q = ret_stack[sp_q];
                    end
                end
            end
            OP_JP: pc_q = nnn;
            OP_CALL: begin
                if (sp_q >= STACK_DEPTH) begin
                    r.st = ST_OVER;
                end else begin
                    ret_stack[sp_q] = pc_q;
                    sp_q++;
                    pc_q = nnn;
                end
            end
            OP_SE_IMM:  if (vreg[x] == kk) pc_q = pc_q + 12'd2;
            OP_SNE_IMM: if (vreg[x] != kk) pc_q = pc_q + 12'd2;
            OP_SE_REG:  if (vreg[x] == vreg[y]) pc_q = pc_q + 12'd2;
            OP_LD_IMM:  vreg[x] = kk;
            OP_ADD_IMM: vreg[x] = vreg[x] + kk;
            OP_ALU: begin
                case (word[3:0])
                    ALU_LD:  vreg[x] = vreg[y];
                    ALU_OR:  vreg[x] = vreg[x] | vreg[y];
                    ALU_AND: vreg[x] = vreg[x] & vreg[y];
                    ALU_XOR: vreg[x] = vreg[x] ^ vreg[y];
                    default: r.st = ST_UNIMPL;
                endcase
            end
            OP_SNE_REG: if (vreg[x] != vreg[y]) pc_q = pc_q + 12'd2;
            OP_LD_I:    idx_q = nnn;
            OP_JP_V0:   pc_q = nnn + {4'h0, vreg[0]};
            default:    r.st = ST_UNIMPL;
        endcase
        r.pc = pc_q;
        r.idx = idx_q;
        r.xv = vreg[x];
        status_count[int'(r.st)]++;
        return r;
    endfunction

    // Mostly well-formed instructions whose operands are biased toward taken skips,
    // with runs of calls and returns that reach both ends of the return stack.
    function automatic logic [INSTR_W-1:0] random_word();
        logic [3:0]         x;
        logic [3:0]         y;
        logic [DATA_W-1:0]  kk;
        logic [INSTR_W-1:0] w;
        x = 4'($urandom_range(0, 15));
        y = ($urandom_range(0, 3) == 0) ? x : 4'($urandom_range(0, 15));
        kk = $urandom_range(0, 1) ? vreg[x] : 8'($urandom);
        w = 16'($urandom);
        if (call_run > 0) begin
            call_run--;
            w = {OP_CALL, 12'($urandom)};
        end else if (ret_run > 0) begin
            ret_run--;
            w = INSTR_RET;
        end else begin
            case ($urandom_range(0, 39))
                0: begin
                    call_run = $urandom_range(16, 19);
                    w = {OP_CALL, 12'($urandom)};
                end
                1: begin
                    ret_run = $urandom_range(16, 19);
                    w = INSTR_RET;
                end
                2, 3, 4:   w = INSTR_RET;
                5:         w = INSTR_CLS;
                6:         w = {OP_SYS, 12'($urandom)};
                7, 8, 9:   w = {OP_CALL, 12'($urandom)};
                10, 11:    w = {OP_SE_IMM, x, kk};
                12, 13:    w = {OP_SNE_IMM, x, kk};
                14, 15:    w = {OP_SE_REG, x, y, 4'($urandom_range(0, 15))};
                16:        w = {OP_SNE_REG, x, y, 4'($urandom_range(0, 15))};
                17, 18, 19: begin
                    // Small values make equal registers common.
                    kk = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom);
                    w = {OP_LD_IMM, x, kk};
                end
                20:        w = {OP_ADD_IMM, x, 8'($urandom)};
                21, 22, 23, 24: w = {OP_ALU, x, y, 4'($urandom_range(0, 3))};
                25:        w = {OP_LD_I, 12'($urandom)};
                26:        w = {OP_JP_V0, 12'($urandom)};
                default:   w = 16'($urandom);
            endcase
        end
        return w;
    endfunction

    task automatic send_instr(input logic [INSTR_W-1:0] word, input logic typed,
                              input result_t typed_res);
        int      gap;
        result_t predicted;
        gap = tx_quiet ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= word;
        do @(posedge aclk); while (!s_tready);
        predicted = execute_instr(word);
        pending_results.push_back(typed ? typed_res : predicted);
        sent_count++;
        @(negedge aclk);
    endtask

    initial begin : result_sink
        int      stall;
        bit      long_hold_done;
        result_t want;
        result_t got;
        m_tready = 1'b0;
        long_hold_done = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (checked_count % 50 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
            stall = rx_quiet ? 0 : $urandom_range(0, 3);
            // One long hold-off lets the block fill up and push back on its input.
            if (checked_count == LONG_HOLD_AT && !long_hold_done) begin
                stall = LONG_HOLD_CYCLES;
                long_hold_done = 1'b1;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            got.pc = m_tdata[11:0];
            got.idx = m_tdata[23:12];
            got.xv = m_tdata[31:24];
            got.st = status_t'(m_tuser);
            if (pending_results.size() == 0) begin
                $error("result beat with no instruction outstanding: %h/%h", m_tdata, m_tuser);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.pc !== want.pc) begin
                    $error("next_pc: expected %h, got %h", want.pc, got.pc);
                    error_count++;
                end
                if (got.idx !== want.idx) begin
                    $error("index_value: expected %h, got %h", want.idx, got.idx);
                    error_count++;
                end
                if (got.xv !== want.xv) begin
                    $error("x_reg_value: expected %h, got %h", want.xv, got.xv);
                    error_count++;
                end
                if (got.st !== want.st) begin
                    $error("status: expected %0d, got %0d", want.st, got.st);
                    error_count++;
                end
            end
            checked_count++;
            @(negedge aclk);
        end
    end

    initial begin : instr_source
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        sent_count = 0;
        call_run = 0;
        ret_run = 0;
        tx_quiet = 1'b0;
        for (int i = 0; i < 4; i++) status_count[i] = 0;
        reset_machine();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int i = 0; i < DIR_N; i++) begin
            for (int k = 0; k < int'(DIRECTED[i].reps); k++) begin
                send_instr(DIRECTED[i].word, DIRECTED[i].typed, DIRECTED[i].res);
            end
        end

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 64 == 0) tx_quiet = ($urandom_range(0, 3) == 0);
            if (i == PAUSE_AT) begin
                s_tvalid <= 1'b0;
                do @(negedge aclk); while (pending_results.size() != 0);
            end
            send_instr(random_word(), 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Executed %0d instructions and checked %0d result beats.",
                 sent_count, checked_count);
        $display("Status mix: ok %0d, stack full %0d, stack empty %0d, unimplemented %0d.",
                 status_count[0], status_count[1], status_count[2], status_count[3]);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
